// ===== hdl/ucd_pkg.sv =====
// Shared types, constants and decode functions for the UTF-8 code point decoder.
`default_nettype none

package ucd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CP_W        = 21;
    localparam int unsigned SEQ_MAX     = 4;
    localparam int unsigned LEN_W       = 3;
    localparam int unsigned MAX_RESULTS = 3;

    localparam logic [BYTE_W-1:0] LEAD_TWO   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_THREE = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD_FOUR  = 8'hF0;
    localparam logic [CP_W-1:0]   QMARK      = 21'h00003F;

    localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
    localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] text_byte;
        logic              final_byte;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last_of_run;
        logic            end_of_text;
    } t_result;

    // One decode request: the bytes of a finished sequence, or all bytes left at end of text
    typedef struct packed {
        logic [SEQ_MAX-1:0][BYTE_W-1:0] bytes;
        logic [LEN_W-1:0]               byte_cnt;
        logic                           final_seq;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [LEN_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [LEN_W-1:0] len;
        priority if (b < LEAD_TWO) begin
            len = LEN_ONE;
        end else if (b < LEAD_THREE) begin
            len = LEN_TWO;
        end else if (b < LEAD_FOUR) begin
            len = LEN_THREE;
        end else begin
            len = LEN_FOUR;
        end
        return len;
    endfunction

    function automatic logic [CP_W-1:0] decode_seq(
        input logic [SEQ_MAX-1:0][BYTE_W-1:0] s,
        input logic [LEN_W-1:0]               len
    );
        logic [CP_W-1:0] cp;
        unique case (len)
            LEN_ONE:   cp = {13'd0, s[0]};
            LEN_TWO:   cp = {10'd0, s[0][4:0], s[1][5:0]};
            LEN_THREE: cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
            default:   cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
        endcase
        return cp;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/ucd_front.sv =====
// Front end: holds bytes of an unfinished sequence and issues decode requests.
`default_nettype none

module ucd_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire ucd_pkg::t_in_item i_item,
    output logic                o_push,
    output ucd_pkg::t_job       o_job
);

    logic [ucd_pkg::BYTE_W-1:0] r_held [0:2];
    logic [1:0]                 r_held_cnt;
    logic [1:0]                 n_held_cnt;

    logic [ucd_pkg::SEQ_MAX-1:0][ucd_pkg::BYTE_W-1:0] buf_bytes;
    logic [ucd_pkg::LEN_W-1:0]  cnt_now;
    logic                       complete;
    logic                       hold_byte;

    always_comb begin
        for (int k = 0; k < ucd_pkg::SEQ_MAX; k++) begin
            if (k < 3 && 2'(k) < r_held_cnt) begin
                buf_bytes[k] = r_held[k < 3 ? k : 0];
            end else if (3'(k) == {1'b0, r_held_cnt}) begin
                buf_bytes[k] = i_item.text_byte;
            end else begin
                buf_bytes[k] = '0;
            end
        end
        cnt_now   = {1'b0, r_held_cnt} + 3'd1;
        complete  = cnt_now >= ucd_pkg::lead_len(buf_bytes[0]);
        hold_byte = i_accept && !i_item.final_byte && !complete;
        o_push    = i_accept && (i_item.final_byte || complete);
        o_job.bytes     = buf_bytes;
        o_job.byte_cnt  = cnt_now;
        o_job.final_seq = i_item.final_byte;
        priority if (hold_byte) begin
            n_held_cnt = r_held_cnt + 2'd1;
        end else if (i_accept) begin
            n_held_cnt = '0;
        end else begin
            n_held_cnt = r_held_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_cnt <= '0;
        end else begin
            r_held_cnt <= n_held_cnt;
        end
    end

    // Hold the byte at the next free place
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (hold_byte && 2'(k) == r_held_cnt) begin
                r_held[k] <= i_item.text_byte;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ucd_queue.sv =====
// Short request queue between the front end and the decode back end.
`default_nettype none

module ucd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire ucd_pkg::t_job  i_job,
    input  wire logic           i_pop,
    output ucd_pkg::t_job       o_job,
    output ucd_pkg::t_q_stat    o_stat
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    ucd_pkg::t_job      r_mem [0:DEPTH-1];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_cnt;
    logic               do_push;
    logic               do_pop;

    assign o_stat.full  = r_cnt == CNT_W'(DEPTH);
    assign o_stat.empty = r_cnt == '0;
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_job        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ucd_back.sv =====
// Back end: walks one decode request and emits code points into the output register.
`default_nettype none

module ucd_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire ucd_pkg::t_job  i_job,
    input  wire logic           i_job_valid,
    output logic                o_job_pop,
    input  wire logic           i_pop,
    output logic                o_empty,
    output ucd_pkg::t_result    o_result
);

    localparam logic [1:0] EMIT_LAST = 2'(ucd_pkg::MAX_RESULTS - 1);

    logic [1:0]              r_pos;
    logic [1:0]              r_emitted;
    logic                    r_out_valid;
    ucd_pkg::t_result        r_out;

    logic [ucd_pkg::SEQ_MAX-1:0][ucd_pkg::BYTE_W-1:0] win;
    logic [ucd_pkg::LEN_W-1:0] len;
    logic [ucd_pkg::LEN_W-1:0] avail;
    logic [ucd_pkg::LEN_W-1:0] adv;
    logic [ucd_pkg::LEN_W-1:0] pos_sum;
    logic [ucd_pkg::CP_W-1:0]  cp;
    logic                      fits;
    logic                      last;
    logic                      advance;

    always_comb begin
        for (int j = 0; j < ucd_pkg::SEQ_MAX; j++) begin
            logic [ucd_pkg::LEN_W-1:0] idx;
            idx = {1'b0, r_pos} + 3'(j);
            win[j] = (idx < 3'(ucd_pkg::SEQ_MAX)) ? i_job.bytes[idx[1:0]] : '0;
        end
        len     = ucd_pkg::lead_len(win[0]);
        avail   = i_job.byte_cnt - {1'b0, r_pos};
        fits    = len <= avail;
        cp      = fits ? ucd_pkg::decode_seq(win, len) : ucd_pkg::QMARK;
        adv     = fits ? len : ucd_pkg::LEN_ONE;
        pos_sum = {1'b0, r_pos} + adv;
        last    = (pos_sum >= i_job.byte_cnt) || (r_emitted == EMIT_LAST);
        advance = i_job_valid && (!r_out_valid || i_pop);
    end

    assign o_job_pop = advance && last;
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_emitted   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                if (last) begin
                    r_pos     <= '0;
                    r_emitted <= '0;
                end else begin
                    r_pos     <= pos_sum[1:0];
                    r_emitted <= r_emitted + 2'd1;
                end
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.code_point  <= cp;
            r_out.last_of_run <= last;
            r_out.end_of_text <= last && i_job.final_seq;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/utf8_codepoint_decoder.sv =====
// Top level of the lenient UTF-8 code point decoder.
//
// Usage:
//   Input channel: present a byte and its final flag on i_item and raise push;
//   the request is taken at a clock edge where push is high and full is low.
//   Output channel: while empty is low the oldest code point sits on o_result;
//   raise pop to take it. The lead byte alone sets the sequence length;
//   following bytes give only their low six bits and are never checked.
//   A completed sequence goes through the request queue and the output register.
//   Throughput: one byte per clock while the receiver pops, set by the back end
//   which retires one decode request per clock when each gives one code point.
//   A final byte that flushes a cut-off sequence gives one to three results,
//   one per clock, while the front keeps taking bytes into the queue.
//   Reset (synchronous, active low) drops all held bytes and queued requests
//   and empties the output register; no clearing pass is needed.
//   When the receiver stalls, the output register holds, the back end stops,
//   the request queue fills and full rises once it holds QUEUE_DEPTH requests.
`default_nettype none

module utf8_codepoint_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire ucd_pkg::t_in_item i_item,
    output logic                   empty,
    input  wire logic              pop,
    output ucd_pkg::t_result       o_result
);

    logic             accept;
    logic             job_push;
    ucd_pkg::t_job    front_job;
    ucd_pkg::t_job    head_job;
    ucd_pkg::t_q_stat q_stat;
    logic             job_pop;

    // Take a byte only while the queue has room for the request it may cause
    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    ucd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_push   (job_push),
        .o_job    (front_job)
    );

    ucd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (front_job),
        .i_pop   (job_pop),
        .o_job   (head_job),
        .o_stat  (q_stat)
    );

    // Advance through the head request one code point per clock while results are taken
    ucd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_valid (!q_stat.empty),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

    // A request is never issued while the queue is full
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(job_push && q_stat.full))
        else $error("decode request issued into a full queue");

    // The back end retires only a request that is present
    a_pop_needs_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_pop |-> !q_stat.empty)
        else $error("request retired from an empty queue");

    // The end of a text always closes the run of its final byte
    a_eot_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.end_of_text) |-> o_result.last_of_run)
        else $error("end of text without last of run");

    // A waiting result holds while the receiver stalls
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed under stall");

endmodule

`default_nettype wire

// ===== tb/sv/utf8_codepoint_decoder_tb.sv =====
// Self-checking testbench for the lenient UTF-8 code point decoder.

// Tracks the code points the decoder owes and checks each one it hands out.
class codepoint_scoreboard;
    ucd_pkg::t_result expected_points[$];
    int unsigned      mismatches;
    logic [7:0]       held[3];
    int unsigned      held_n;
    logic [7:0]       work[4];

    function new();
        mismatches = 0;
        held_n     = 0;
    endfunction

    function int unsigned seq_len(input logic [7:0] b);
        if (b < ucd_pkg::LEAD_TWO) begin
            return 1;
        end else if (b < ucd_pkg::LEAD_THREE) begin
            return 2;
        end else if (b < ucd_pkg::LEAD_FOUR) begin
            return 3;
        end
        return 4;
    endfunction

    // Build the code point of the sequence that starts at work[s].
    function logic [20:0] assemble(input int unsigned s, input int unsigned len);
        logic [20:0] cp;
        case (len)
            1: cp = {13'd0, work[s]};
            2: cp = {10'd0, work[s][4:0], work[s+1][5:0]};
            3: cp = {5'd0, work[s][3:0], work[s+1][5:0], work[s+2][5:0]};
            default: cp = {work[s][2:0], work[s+1][5:0], work[s+2][5:0], work[s+3][5:0]};
        endcase
        return cp;
    endfunction

    function void take_byte(input ucd_pkg::t_in_item it);
        ucd_pkg::t_result run[$];
        ucd_pkg::t_result r;
        int unsigned      n;
        int unsigned      p;
        int unsigned      len;
        for (int i = 0; i < held_n; i++) work[i] = held[i];
        work[held_n] = it.text_byte;
        n = held_n + 1;
        if (!it.final_byte) begin
            len = seq_len(work[0]);
            if (n >= len) begin
                r.code_point  = assemble(0, len);
                r.last_of_run = 1'b1;
                r.end_of_text = 1'b0;
                expected_points.push_back(r);
                held_n = 0;
            end else begin
                for (int i = 0; i < n; i++) held[i] = work[i];
                held_n = n;
            end
            return;
        end
        // End of text: a cut-off lead gives '?' and the scan resumes after it
        p = 0;
        while (p < n && run.size() < 3) begin
            len = seq_len(work[p]);
            r.last_of_run = 1'b0;
            r.end_of_text = 1'b0;
            if (p + len <= n) begin
                r.code_point = assemble(p, len);
                p += len;
            end else begin
                r.code_point = ucd_pkg::QMARK;
                p += 1;
            end
            run.push_back(r);
        end
        run[run.size()-1].last_of_run = 1'b1;
        run[run.size()-1].end_of_text = 1'b1;
        foreach (run[i]) expected_points.push_back(run[i]);
        held_n = 0;
    endfunction

    function void match_point(input ucd_pkg::t_result got);
        ucd_pkg::t_result want;
        if (expected_points.size() == 0) begin
            $display("%0t unexpected code point: expected none, actual %h/%b/%b", $time,
                     got.code_point, got.last_of_run, got.end_of_text);
            mismatches++;
            return;
        end
        want = expected_points.pop_front();
        if (got.code_point !== want.code_point) begin
            $display("%0t code_point mismatch: expected %h, actual %h", $time,
                     want.code_point, got.code_point);
            mismatches++;
        end
        if (got.last_of_run !== want.last_of_run) begin
            $display("%0t last_of_run mismatch: expected %b, actual %b", $time,
                     want.last_of_run, got.last_of_run);
            mismatches++;
        end
        if (got.end_of_text !== want.end_of_text) begin
            $display("%0t end_of_text mismatch: expected %b, actual %b", $time,
                     want.end_of_text, got.end_of_text);
            mismatches++;
        end
    endfunction

    function int unsigned pending();
        return expected_points.size();
    endfunction
endclass

module utf8_codepoint_decoder_tb;

    localparam int unsigned IDLE_LIMIT    = 4000;  // cycles with no request moved
    localparam int unsigned BYTE_TARGET   = 460;   // bytes to offer in all
    localparam int unsigned RX_HOLD_TIME  = 200;   // long receiver hold-off
    localparam int unsigned TAIL_CYCLES   = 20;    // settle time after the last result

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    ucd_pkg::t_in_item i_item;
    logic              empty;
    logic              pop;
    ucd_pkg::t_result  o_result;

    codepoint_scoreboard sb;

    bit          tx_steady;     // sender offers back to back
    bit          rx_steady;     // receiver takes every cycle
    bit          rx_hold_req;   // ask the receiver for one long hold-off
    int unsigned bytes_sent;

    utf8_codepoint_decoder dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Offer one byte after an optional gap; hold it until the decoder takes it.
    // Push is left high so that the next call can follow without a bubble.
    task automatic send_byte(input logic [7:0] b, input bit fin);
        int unsigned       gap;
        ucd_pkg::t_in_item it;
        it.text_byte  = b;
        it.final_byte = fin;
        gap = tx_steady ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= it;
        // Sample full at the edge: the request moves where push is high and full low
        do @(posedge i_clk); while (full);
        sb.take_byte(it);
        bytes_sent++;
    endtask

    // Send a whole text; the flag rides on its last byte.
    task automatic send_text(input logic [7:0] txt[$]);
        foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
    endtask

    // Drop push, then wait until the decoder has handed out everything owed.
    task automatic wait_drain();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Append the first keep bytes of one character of the given length with random content.
    task automatic add_char(ref logic [7:0] txt[$], input int unsigned len,
                            input int unsigned keep);
        case (len)
            1: txt.push_back(8'($urandom_range(8'h00, 8'h7F)));
            2: txt.push_back(8'($urandom_range(8'h80, 8'hDF)));
            3: txt.push_back(8'($urandom_range(8'hE0, 8'hEF)));
            default: txt.push_back(8'($urandom_range(8'hF0, 8'hFF)));
        endcase
        // Continuation bytes are not checked, so stray values now and then
        for (int i = 1; i < keep; i++) begin
            if ($urandom_range(0, 99) < 85) begin
                txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end else begin
                txt.push_back(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Receiver: draw pop at the falling edge, take the result at the rising edge.
    initial begin
        int unsigned hold_left;
        int unsigned stall_left;
        hold_left  = 0;
        stall_left = 0;
        pop        = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                hold_left   = RX_HOLD_TIME;
                rx_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
            @(posedge i_clk);
            if (pop && !empty) begin
                sb.match_point(o_result);
                stall_left = rx_steady ? 0 : pick_gap();
            end
        end
    end

    // Watchdog: give up once nothing has moved for too long.
    initial begin
        int unsigned idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty)) begin
                idle = 0;
            end else begin
                idle++;
            end
            if (idle >= IDLE_LIMIT) begin
                $display("FAIL utf8_codepoint_decoder");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        logic [7:0]  txt[$];
        int unsigned n_chars;
        int unsigned len;
        int unsigned texts;
        int unsigned r;

        sb          = new();
        push        = 1'b0;
        i_item      = '0;
        i_rst_n     = 1'b0;
        tx_steady   = 1'b0;
        rx_steady   = 1'b0;
        rx_hold_req = 1'b0;
        bytes_sent  = 0;
        texts       = 0;

        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: ASCII extremes, two-byte with a stray continuation lead,
        // three- and four-byte extremes, all ending cleanly
        txt = '{8'h00, 8'hC2, 8'hA9, 8'hDF, 8'hBF, 8'h80, 8'h80,
                8'hE0, 8'h80, 8'h80, 8'hEF, 8'hBF, 8'hBF, 8'h7F};
        send_text(txt);
        txt = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_text(txt);
        // Final byte completes a held four-byte sequence
        txt = '{8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text(txt);
        // Cut-off lead followed by ASCII: '?' then the letter
        txt = '{8'hF0, 8'h41};
        send_text(txt);
        // Cut-off lead and cut-off stray continuation: two '?'
        txt = '{8'hE1, 8'h80};
        send_text(txt);
        // Two cut-off leads then ASCII: three results from one final byte
        txt = '{8'hF0, 8'hF0, 8'h41};
        send_text(txt);
        // One-byte text
        txt = '{8'h41};
        send_text(txt);
        wait_drain();

        // Random texts
        while (bytes_sent < BYTE_TARGET) begin
            txt.delete();
            r = $urandom_range(0, 99);
            tx_steady = ($urandom_range(0, 99) < 20);
            rx_steady = ($urandom_range(0, 99) < 20);
            if (texts == 5) begin
                // Fill the decoder: receiver holds off while bytes keep coming
                tx_steady   = 1'b1;
                rx_hold_req = 1'b1;
                for (int i = 0; i < 16; i++) add_char(txt, 1, 1);
            end else if (r < 10) begin
                // Noise: raw bytes of any value
                n_chars = $urandom_range(1, 10);
                for (int i = 0; i < n_chars; i++) txt.push_back(8'($urandom_range(0, 255)));
            end else begin
                n_chars = $urandom_range(1, 8);
                for (int i = 0; i < n_chars; i++) begin
                    len = $urandom_range(1, 4);
                    add_char(txt, len, len);
                end
                // Cut the text off inside a sequence now and then
                if (r < 35) begin
                    len = $urandom_range(2, 4);
                    add_char(txt, len, $urandom_range(1, len - 1));
                end
            end
            send_text(txt);
            texts++;
            if (texts % 25 == 0) begin
                // Pause until every owed code point has come out
                wait_drain();
            end
        end

        @(negedge i_clk);
        push <= 1'b0;
        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS utf8_codepoint_decoder");
        end else begin
            $display("FAIL utf8_codepoint_decoder");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ucd_pkg.sv
hdl/ucd_front.sv
hdl/ucd_queue.sv
hdl/ucd_back.sv
hdl/utf8_codepoint_decoder.sv
tb/sv/utf8_codepoint_decoder_tb.sv
